@@ src/mfqs_pkg.sv @@
package mfqs_pkg;

    localparam int DEF_LEVELS  = 4;
    localparam int DEF_THREADS = 16;

    localparam int OP_W      = 2;
    localparam int ID_W      = 4;
    localparam int ID_SPACE  = 1 << ID_W;
    localparam int LEVEL_W   = 2;
    localparam int ALLOT_W   = 8;
    localparam int NUM_ALLOT = 4;
    localparam int CFG_IDX_W = 2;
    localparam int QC_W      = 5;

    typedef logic [ID_W-1:0]    thread_id_t;
    typedef logic [ALLOT_W-1:0] allot_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_YIELD = 2'd2,
        OP_EXIT  = 2'd3
    } op_t;

    localparam allot_t ALLOT_RESET [NUM_ALLOT] = '{8'd1, 8'd2, 8'd3, 8'd4};

endpackage

@@ src/multilevel_feedback_queue_scheduler_core.sv @@
// Multilevel feedback queue scheduler. Each request (add, tick, yield or exit) yields exactly
// one result carrying the running thread, its level, a switch flag, the number of queued
// threads and an add-rejected flag. A request is registered on acceptance and its result is
// registered from it once the result side is not stalled, and a new request can be accepted
// every cycle while the result side is not stalled; a single combinational pass pushes onto
// a level's linked list and pops the head of the lowest-numbered non-empty level for each
// result. Allotment registers may only be written while no request is in flight.
module multilevel_feedback_queue_scheduler_core
#(
    parameter int LEVELS  = mfqs_pkg::DEF_LEVELS,
    parameter int THREADS = mfqs_pkg::DEF_THREADS
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write,
    input  logic [mfqs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfqs_pkg::ALLOT_W-1:0]   cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mfqs_pkg::OP_W-1:0]   operation,
    input  logic [mfqs_pkg::ID_W-1:0]   thread_id,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        running_valid,
    output logic [mfqs_pkg::ID_W-1:0]   running_id,
    output logic [mfqs_pkg::LEVEL_W-1:0] running_level,
    output logic                        switched,
    output logic [mfqs_pkg::QC_W-1:0]   queued_count,
    output logic                        add_rejected
);
    import mfqs_pkg::*;

    localparam int LIDX_W = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(THREADS + 1);

    typedef logic [LIDX_W-1:0] lidx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // configuration
    allot_t allot_reg [NUM_ALLOT];

    // queue state
    thread_id_t link_reg [ID_SPACE];
    thread_id_t head_reg [LEVELS];
    thread_id_t tail_reg [LEVELS];
    cnt_t       size_reg [LEVELS];
    cnt_t       total_reg;
    logic       cur_valid_reg;
    thread_id_t cur_id_reg;
    lidx_t      cur_level_reg;
    allot_t     run_ticks_reg;

    // request register
    logic       s1_valid_reg;
    op_t        s1_op_reg;
    thread_id_t s1_tid_reg;

    // result register
    logic             out_valid_reg;
    logic             running_valid_reg;
    thread_id_t       running_id_reg;
    logic [LEVEL_W-1:0] running_level_reg;
    logic             switched_reg;
    logic [QC_W-1:0]  queued_count_reg;
    logic             add_rejected_reg;

    logic in_accept;
    logic adv;

    thread_id_t head_next [LEVELS];
    thread_id_t tail_next [LEVELS];
    cnt_t       size_next [LEVELS];
    cnt_t       total_next;
    logic       cur_valid_next;
    thread_id_t cur_id_next;
    lidx_t      cur_level_next;
    allot_t     run_ticks_next;
    logic       rejected;
    logic       switched_next;
    logic       link_we;
    thread_id_t link_waddr;
    thread_id_t link_wdata;
    cnt_t       size_sum;

    assign adv       = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !adv;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        allot_t     ticks_inc;
        allot_t     allot_cur;
        lidx_t      demote_lvl;
        logic       push_en;
        lidx_t      push_lvl;
        thread_id_t push_id;
        logic       do_sel;
        logic       sel_found;
        lidx_t      sel_lvl;
        thread_id_t sel_head;
        thread_id_t sel_link;

        head_next      = head_reg;
        tail_next      = tail_reg;
        size_next      = size_reg;
        total_next     = total_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        cur_level_next = cur_level_reg;
        run_ticks_next = run_ticks_reg;
        rejected       = 1'b0;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        push_en        = 1'b0;
        push_lvl       = '0;
        push_id        = '0;
        do_sel         = 1'b0;

        ticks_inc  = (run_ticks_reg == '1) ? run_ticks_reg : run_ticks_reg + allot_t'(1);
        allot_cur  = allot_reg[CFG_IDX_W'(cur_level_reg)];
        demote_lvl = (cur_level_reg == lidx_t'(LEVELS - 1)) ? cur_level_reg
                                                            : cur_level_reg + lidx_t'(1);

        if (s1_op_reg == OP_ADD)
        begin
            if ((CNT_W+1)'(total_reg) + (CNT_W+1)'(cur_valid_reg) >= (CNT_W+1)'(THREADS))
            begin
                rejected = 1'b1;
            end
            else
            begin
                push_en  = 1'b1;
                push_lvl = '0;
                push_id  = s1_tid_reg;
            end
        end
        else if (!cur_valid_reg)
        begin
            do_sel = 1'b1;
        end
        else
        begin
            run_ticks_next = ticks_inc;
            if (s1_op_reg == OP_EXIT)
            begin
                do_sel = 1'b1;
            end
            else if (s1_op_reg == OP_YIELD || ticks_inc >= allot_cur)
            begin
                push_en  = 1'b1;
                push_lvl = demote_lvl;
                push_id  = cur_id_reg;
                do_sel   = 1'b1;
            end
        end

        // requeue or add at the tail
        if (push_en)
        begin
            if (size_next[push_lvl] == '0)
            begin
                head_next[push_lvl] = push_id;
            end
            else
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg[push_lvl];
                link_wdata = push_id;
            end
            tail_next[push_lvl] = push_id;
            size_next[push_lvl] = size_next[push_lvl] + cnt_t'(1);
            total_next          = total_next + cnt_t'(1);
        end

        // lowest-numbered non-empty level
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (size_next[l] != '0)
            begin
                sel_found = 1'b1;
                sel_lvl   = lidx_t'(l);
            end
        end
        sel_head = head_next[sel_lvl];
        sel_link = (link_we && link_waddr == sel_head) ? link_wdata : link_reg[sel_head];

        if (do_sel)
        begin
            cur_valid_next = 1'b0;
            cur_id_next    = '0;
            cur_level_next = '0;
            run_ticks_next = '0;
            if (sel_found)
            begin
                if (size_next[sel_lvl] > cnt_t'(1))
                begin
                    head_next[sel_lvl] = sel_link;
                end
                size_next[sel_lvl] = size_next[sel_lvl] - cnt_t'(1);
                total_next         = total_next - cnt_t'(1);
                cur_valid_next     = 1'b1;
                cur_id_next        = sel_head;
                cur_level_next     = sel_lvl;
            end
        end

        switched_next = (cur_valid_reg != cur_valid_next)
                        || (cur_valid_next && cur_id_reg != cur_id_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALLOT; i++)
            begin
                allot_reg[i] <= ALLOT_RESET[i];
            end
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                size_reg[l] <= '0;
            end
            total_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            cur_level_reg <= '0;
            run_ticks_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                allot_reg[cfg_index] <= cfg_data;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                size_reg      <= size_next;
                total_reg     <= total_next;
                cur_valid_reg <= cur_valid_next;
                cur_id_reg    <= cur_id_next;
                cur_level_reg <= cur_level_next;
                run_ticks_reg <= run_ticks_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg  <= op_t'(operation);
            s1_tid_reg <= thread_id;
        end
        if (adv)
        begin
            if (link_we)
            begin
                link_reg[link_waddr] <= link_wdata;
            end
            running_valid_reg <= cur_valid_next;
            running_id_reg    <= cur_valid_next ? cur_id_next : '0;
            running_level_reg <= cur_valid_next ? LEVEL_W'(cur_level_next) : '0;
            switched_reg      <= switched_next;
            queued_count_reg  <= QC_W'(total_next);
            add_rejected_reg  <= rejected;
        end
    end

    assign out_valid     = out_valid_reg;
    assign running_valid = running_valid_reg;
    assign running_id    = running_id_reg;
    assign running_level = running_level_reg;
    assign switched      = switched_reg;
    assign queued_count  = queued_count_reg;
    assign add_rejected  = add_rejected_reg;

    always_comb
    begin
        size_sum = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            size_sum = size_sum + size_reg[l];
        end
    end

    a_total_matches_levels: assert property (@(posedge clk) disable iff (!rst_n)
        size_sum == total_reg)
        else $error("total queued differs from sum of level sizes");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(total_reg) + (CNT_W+1)'(cur_valid_reg) <= (CNT_W+1)'(THREADS))
        else $error("queued plus running exceeds capacity");

    a_idle_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        !cur_valid_reg |-> (run_ticks_reg == '0 && cur_level_reg == '0))
        else $error("tick count or level held with nothing running");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without a blocked request");

endmodule
